### hdl/rv32ex_pkg.sv
package rv32ex_pkg;

  // Datapath and storage sizes
  localparam int unsigned XLEN       = 32;
  localparam int unsigned NUM_REGS   = 32;
  localparam int unsigned REG_AW     = $clog2(NUM_REGS);
  // Data memory depth in words; a power of two so the word index is a plain bit slice
  localparam int unsigned DATA_WORDS = 1024;
  localparam int unsigned DMEM_AW    = $clog2(DATA_WORDS);

  // Major opcodes of the supported subset
  typedef enum logic [6:0] {
    OPC_AUIPC  = 7'h17,
    OPC_IMM    = 7'h13,
    OPC_LOAD   = 7'h03,
    OPC_STORE  = 7'h23,
    OPC_REG    = 7'h33,
    OPC_BRANCH = 7'h63
  } opcode_e;

  // funct3 / funct7 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_SUB  = 7'h20;

  // Register file write port
  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  // Data memory access from the execute stage
  typedef struct packed {
    logic               en;
    logic               we;
    logic [DMEM_AW-1:0] addr;
    logic [XLEN-1:0]    wdata;
  } dmem_req_t;

  // Executed instruction on its way to writeback
  typedef struct packed {
    logic [XLEN-1:0]   pc;
    logic [XLEN-1:0]   npc;
    logic              wr;
    logic [REG_AW-1:0] rd;
    logic              is_load;
    logic [XLEN-1:0]   alu;
    logic              st;
    logic [XLEN-1:0]   saddr;
    logic [XLEN-1:0]   sdata;
    logic              bad;
  } exec_t;

  // Result item as presented at the output
  typedef struct packed {
    logic [XLEN-1:0]   instr_pc;
    logic [XLEN-1:0]   next_pc;
    logic              reg_write;
    logic [REG_AW-1:0] dest_reg;
    logic [XLEN-1:0]   write_value;
    logic              store_valid;
    logic [XLEN-1:0]   store_address;
    logic [XLEN-1:0]   store_data;
    logic              unsupported;
  } result_t;

endpackage

### hdl/rv32ex_instr_if.sv
interface rv32ex_instr_if;
  import rv32ex_pkg::*;

  logic            valid;
  logic            ready;
  logic [XLEN-1:0] instr;

  modport source (output valid, output instr, input ready);
  modport sink   (input valid, input instr, output ready);
endinterface

### hdl/rv32ex_result_if.sv
interface rv32ex_result_if;
  import rv32ex_pkg::*;

  logic              valid;
  logic              ready;
  logic [XLEN-1:0]   instr_pc;
  logic [XLEN-1:0]   next_pc;
  logic              reg_write;
  logic [REG_AW-1:0] dest_reg;
  logic [XLEN-1:0]   write_value;
  logic              store_valid;
  logic [XLEN-1:0]   store_address;
  logic [XLEN-1:0]   store_data;
  logic              unsupported;

  modport source (
    output valid, output instr_pc, output next_pc, output reg_write, output dest_reg,
    output write_value, output store_valid, output store_address, output store_data,
    output unsupported, input ready
  );
  modport sink (
    input valid, input instr_pc, input next_pc, input reg_write, input dest_reg,
    input write_value, input store_valid, input store_address, input store_data,
    input unsupported, output ready
  );
endinterface

### hdl/rv32ex_regfile.sv
module rv32ex_regfile (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  logic [rv32ex_pkg::REG_AW-1:0]       rs1_i,
  input  logic [rv32ex_pkg::REG_AW-1:0]       rs2_i,
  input  rv32ex_pkg::rf_wr_t                  wr_i,
  output logic [rv32ex_pkg::XLEN-1:0]         rs1_data_o,
  output logic [rv32ex_pkg::XLEN-1:0]         rs2_data_o
);
  import rv32ex_pkg::*;

  logic [XLEN-1:0]     mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid_q;
  logic [XLEN-1:0]     rd1_q, rd2_q, byp_data_q;
  logic                v1_q, v2_q, byp1_q, byp2_q;

  // Storage array: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd1_q      <= mem[rs1_i];
      rd2_q      <= mem[rs2_i];
      byp_data_q <= wr_i.data;
    end
  end

  // Written flags (unwritten entries read zero) and same-edge write bypass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      byp1_q  <= 1'b0;
      byp2_q  <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        v1_q   <= valid_q[rs1_i];
        v2_q   <= valid_q[rs2_i];
        byp1_q <= wr_i.we && (wr_i.addr == rs1_i);
        byp2_q <= wr_i.we && (wr_i.addr == rs2_i);
      end
    end
  end

  assign rs1_data_o = byp1_q ? byp_data_q : (v1_q ? rd1_q : '0);
  assign rs2_data_o = byp2_q ? byp_data_q : (v2_q ? rd2_q : '0);

endmodule

### hdl/rv32ex_dmem.sv
module rv32ex_dmem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rv32ex_pkg::dmem_req_t       req_i,
  output logic [rv32ex_pkg::XLEN-1:0] rdata_o,
  output logic                        clr_done_o
);
  import rv32ex_pkg::*;

  logic [XLEN-1:0]    mem [DATA_WORDS];
  logic [XLEN-1:0]    rdata_q;
  logic [DMEM_AW:0]   clr_cnt_q;
  logic               clearing;
  logic               mem_we;
  logic [DMEM_AW-1:0] mem_waddr;
  logic [XLEN-1:0]    mem_wdata;

  assign clearing = !clr_cnt_q[DMEM_AW];

  // Clearing pass owns the write port until every word is zero
  always_comb begin
    mem_we    = clearing || (req_i.en && req_i.we);
    mem_waddr = clearing ? clr_cnt_q[DMEM_AW-1:0] : req_i.addr;
    mem_wdata = clearing ? '0 : req_i.wdata;
  end

  // One write port and one read port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (req_i.en && !req_i.we) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  // Sweep counter, one word per cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clearing) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_done_o = !clearing;

endmodule

### hdl/rv32i_subset_execute_unit.sv
// Channel   Dir  Port      Payload
// --------  ---  --------  ---------------------------------------------------------
// instr     in   instr_i   instr
// result    out  result_o  instr_pc, next_pc, reg_write, dest_reg, write_value,
//                          store_valid, store_address, store_data, unsupported
//
// One instruction per cycle sustained while result_o accepts; a result is offered once it has passed
// the operand registers, execute with data memory access, and the memory stage and output registers.
// Hazards are forwarded from writeback, so dependent instructions, loads too, never stall.
// After reset the data memory is swept to zero, one word a cycle, with instr_i.ready low
// until all DATA_WORDS (1024) words are clear.
// A stalled result_o holds the pipeline; instr_i.ready drops once all stages are full.
module rv32i_subset_execute_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  rv32ex_instr_if.sink   instr_i,
  rv32ex_result_if.source result_o
);
  import rv32ex_pkg::*;

  logic            clr_done;
  logic            in_xfer, e1_adv, e2_adv, out_free;
  logic            e1_valid_q, e2_valid_q, out_valid_q;
  logic [XLEN-1:0] e1_instr_q;
  logic [XLEN-1:0] pc_q;
  exec_t           e1_x, e2_q;
  result_t         res_q;
  rf_wr_t          rf_wr;
  dmem_req_t       dmem_req;
  logic [XLEN-1:0] rf_rs1, rf_rs2, opa, opb;
  logic [XLEN-1:0] dmem_rdata, e2_wval;
  logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_u, maddr;
  logic            lt;
  opcode_e         opc;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [REG_AW-1:0] rd, rs1, rs2;

  // Pipeline flow control
  assign out_free      = !out_valid_q || result_o.ready;
  assign e2_adv        = e2_valid_q && out_free;
  assign e1_adv        = e1_valid_q && (!e2_valid_q || e2_adv);
  assign instr_i.ready = clr_done && (!e1_valid_q || e1_adv);
  assign in_xfer       = instr_i.valid && instr_i.ready;

  // Register file, read as the instruction transfers in
  rv32ex_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_xfer),
    .rs1_i      (instr_i.instr[19:15]),
    .rs2_i      (instr_i.instr[24:20]),
    .wr_i       (rf_wr),
    .rs1_data_o (rf_rs1),
    .rs2_data_o (rf_rs2)
  );

  // Writeback value and register write at the end of the memory stage
  assign e2_wval = e2_q.is_load ? dmem_rdata : e2_q.alu;
  always_comb begin
    rf_wr.we   = e2_adv && e2_q.wr;
    rf_wr.addr = e2_q.rd;
    rf_wr.data = e2_wval;
  end

  // Instruction fields
  assign opc = opcode_e'(e1_instr_q[6:0]);
  assign rd  = e1_instr_q[11:7];
  assign f3  = e1_instr_q[14:12];
  assign rs1 = e1_instr_q[19:15];
  assign rs2 = e1_instr_q[24:20];
  assign f7  = e1_instr_q[31:25];

  // Forward from the older instruction still in the memory stage
  assign opa = (e2_valid_q && e2_q.wr && (e2_q.rd == rs1)) ? e2_wval : rf_rs1;
  assign opb = (e2_valid_q && e2_q.wr && (e2_q.rd == rs2)) ? e2_wval : rf_rs2;

  // Immediates
  assign imm_i = {{20{e1_instr_q[31]}}, e1_instr_q[31:20]};
  assign imm_s = {{20{e1_instr_q[31]}}, e1_instr_q[31:25], e1_instr_q[11:7]};
  assign imm_b = {{20{e1_instr_q[31]}}, e1_instr_q[7], e1_instr_q[30:25],
                  e1_instr_q[11:8], 1'b0};
  assign imm_u = {e1_instr_q[31:12], 12'b0};
  assign lt    = $signed(opa) < $signed(opb);
  assign maddr = opa + ((opc == OPC_STORE) ? imm_s : imm_i);

  // Decode and execute
  always_comb begin
    e1_x         = '0;
    e1_x.pc      = pc_q;
    e1_x.npc     = pc_q + XLEN'(4);
    e1_x.rd      = rd;
    case (opc)
      OPC_AUIPC: begin
        e1_x.wr  = 1'b1;
        e1_x.alu = pc_q + imm_u;
      end
      OPC_IMM: begin
        if (f3 == F3_ADD) begin
          e1_x.wr  = 1'b1;
          e1_x.alu = maddr;
        end else begin
          e1_x.bad = 1'b1;
        end
      end
      OPC_LOAD: begin
        if (f3 == F3_WORD) begin
          e1_x.wr      = 1'b1;
          e1_x.is_load = 1'b1;
        end else begin
          e1_x.bad = 1'b1;
        end
      end
      OPC_STORE: begin
        if (f3 == F3_WORD) begin
          e1_x.st    = 1'b1;
          e1_x.saddr = maddr;
          e1_x.sdata = opb;
        end else begin
          e1_x.bad = 1'b1;
        end
      end
      OPC_REG: begin
        if (f3 == F3_ADD && f7 == F7_BASE) begin
          e1_x.wr  = 1'b1;
          e1_x.alu = opa + opb;
        end else if (f3 == F3_ADD && f7 == F7_SUB) begin
          e1_x.wr  = 1'b1;
          e1_x.alu = opa - opb;
        end else if (f3 == F3_SLT && f7 == F7_BASE) begin
          e1_x.wr  = 1'b1;
          e1_x.alu = {{(XLEN-1){1'b0}}, lt};
        end else begin
          e1_x.bad = 1'b1;
        end
      end
      OPC_BRANCH: begin
        if (f3 == F3_BLT) begin
          if (lt) begin
            e1_x.npc = pc_q + imm_b;
          end
        end else begin
          e1_x.bad = 1'b1;
        end
      end
      default: begin
        e1_x.bad = 1'b1;
      end
    endcase
    // x0 writes are dropped
    if (rd == '0) begin
      e1_x.wr  = 1'b0;
      e1_x.alu = '0;
    end
  end

  // Data memory port: load read or store write as the instruction leaves execute
  always_comb begin
    dmem_req.en    = e1_adv && (e1_x.is_load || e1_x.st);
    dmem_req.we    = e1_x.st;
    dmem_req.addr  = maddr[DMEM_AW+1:2];
    dmem_req.wdata = opb;
  end

  rv32ex_dmem u_dmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (dmem_req),
    .rdata_o    (dmem_rdata),
    .clr_done_o (clr_done)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      e1_valid_q  <= 1'b0;
      e2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (e1_adv) begin
        pc_q <= e1_x.npc;
      end
      if (in_xfer) begin
        e1_valid_q <= 1'b1;
      end else if (e1_adv) begin
        e1_valid_q <= 1'b0;
      end
      if (e1_adv) begin
        e2_valid_q <= 1'b1;
      end else if (e2_adv) begin
        e2_valid_q <= 1'b0;
      end
      if (e2_adv) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      e1_instr_q <= instr_i.instr;
    end
    if (e1_adv) begin
      e2_q <= e1_x;
    end
    if (e2_adv) begin
      res_q.instr_pc      <= e2_q.pc;
      res_q.next_pc       <= e2_q.npc;
      res_q.reg_write     <= e2_q.wr;
      res_q.dest_reg      <= e2_q.wr ? e2_q.rd : '0;
      res_q.write_value   <= e2_q.wr ? e2_wval : '0;
      res_q.store_valid   <= e2_q.st;
      res_q.store_address <= e2_q.saddr;
      res_q.store_data    <= e2_q.sdata;
      res_q.unsupported   <= e2_q.bad;
    end
  end

  // Output channel
  assign result_o.valid         = out_valid_q;
  assign result_o.instr_pc      = res_q.instr_pc;
  assign result_o.next_pc       = res_q.next_pc;
  assign result_o.reg_write     = res_q.reg_write;
  assign result_o.dest_reg      = res_q.dest_reg;
  assign result_o.write_value   = res_q.write_value;
  assign result_o.store_valid   = res_q.store_valid;
  assign result_o.store_address = res_q.store_address;
  assign result_o.store_data    = res_q.store_data;
  assign result_o.unsupported   = res_q.unsupported;

`ifndef ASSERT_OFF
  a_no_xfer_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> clr_done)
    else $error("instruction taken during memory clear");

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.we |-> (rf_wr.addr != '0))
    else $error("register file write to x0");

  a_pc_moves_with_execute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !e1_adv |=> $stable(pc_q))
    else $error("pc changed without an instruction leaving execute");

  a_unsupported_is_nop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.unsupported) |-> (!res_q.reg_write && !res_q.store_valid))
    else $error("unsupported instruction changed state");

  a_blocked_execute_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e1_valid_q && e2_valid_q && !e2_adv) |=> e1_valid_q)
    else $error("execute stage dropped a stalled instruction");
`endif

endmodule
